@@ hw/rtl/log_record_block_framer_unit_assert.svh @@
// Assertion macros used by the port checker of the log record block framer.
`ifndef LOG_RECORD_BLOCK_FRAMER_UNIT_ASSERT_SVH
`define LOG_RECORD_BLOCK_FRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRBF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lrbf_pkg.sv @@
// Package of the log record block framer: sizes, codes, word types and CRC32C helpers.
`timescale 1ns / 1ps
package lrbf_pkg;

	// The block size must be a power of two.
	localparam int BLOCK_SIZE  = 32768;
	localparam int OFFSET_BITS = 48;
	localparam int FIELD_W     = 48;
	localparam int BLOCK_BITS  = $clog2(BLOCK_SIZE);
	localparam int HEADER_LEN  = 7;

	typedef logic [OFFSET_BITS-1:0] pos_t;
	typedef logic [FIELD_W-1:0]     field48_t;
	typedef logic [BLOCK_BITS-1:0]  blk_off_t;

	// A block offset above this leaves less room than one header.
	localparam blk_off_t PAD_LIMIT = blk_off_t'(BLOCK_SIZE - HEADER_LEN);

	localparam logic [31:0] CRC_POLY       = 32'h82F6_3B78;
	localparam logic [31:0] CRC_MASK_DELTA = 32'hA282_EAD8;

	localparam logic [7:0] FRAG_FULL   = 8'd1;
	localparam logic [7:0] FRAG_FIRST  = 8'd2;
	localparam logic [7:0] FRAG_MIDDLE = 8'd3;
	localparam logic [7:0] FRAG_LAST   = 8'd4;

	typedef enum logic [0:0] {
		FUNC_DATA = 1'b0,
		FUNC_END  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		KIND_PAD = 2'd0,
		KIND_HDR = 2'd1,
		KIND_PAY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		HB_CRC0,
		HB_CRC1,
		HB_CRC2,
		HB_CRC3,
		HB_LEN_LO,
		HB_LEN_HI,
		HB_TYPE
	} hdr_byte_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] log_byte;
		field48_t   log_offset;
		kind_t      kind;
		logic       last_result;
	} result_t;

	// Reflected CRC32C update by one byte, one bit per step.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
			input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Final inversion followed by the rotate-and-add mask of the log format.
	function automatic logic [31:0] crc_mask(input logic [31:0] raw);
		logic [31:0] c;
		c = ~raw;
		return {c[14:0], c[31:15]} + CRC_MASK_DELTA;
	endfunction

	// Running CRC values after the type byte, one for each fragment type.
	localparam logic [31:0] CRC_INIT_FULL   = crc32c_byte(32'hFFFF_FFFF, FRAG_FULL);
	localparam logic [31:0] CRC_INIT_FIRST  = crc32c_byte(32'hFFFF_FFFF, FRAG_FIRST);
	localparam logic [31:0] CRC_INIT_MIDDLE = crc32c_byte(32'hFFFF_FFFF, FRAG_MIDDLE);
	localparam logic [31:0] CRC_INIT_LAST   = crc32c_byte(32'hFFFF_FFFF, FRAG_LAST);

endpackage

@@ hw/rtl/lrbf_in_reg.sv @@
// Input register: holds one accepted word until the framer has sent its final result.
`timescale 1ns / 1ps
module lrbf_in_reg import lrbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  rec_valid,
	output logic  rec_stall,
	input  item_t item_in,
	input  logic  item_done,
	output logic  item_valid_s1,
	output item_t item_s1
);

	logic load;

	// A word may enter in the same cycle as the held one leaves.
	assign rec_stall = item_valid_s1 && !item_done;
	assign load      = rec_valid && !rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (load) begin
			item_valid_s1 <= 1'b1;
		end else if (item_done) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

@@ hw/rtl/lrbf_framer.sv @@
// Framer core: fragment state, dual running CRC32C and one log byte per step.
`timescale 1ns / 1ps
module lrbf_framer import lrbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start_offset_we,
	input  field48_t start_offset,
	input  logic     item_valid_s1,
	input  item_t    item_s1,
	input  logic     res_ready,
	output logic     res_push,
	output result_t  res,
	output logic     item_done
);

	pos_t        wp_q;
	pos_t        hp_q;
	logic [15:0] len_q;
	logic        open_q;
	logic        first_q;
	logic [31:0] crc_end_q;
	logic [31:0] crc_cont_q;
	hdr_byte_t   hdr_idx_q;

	pos_t        e_wp;
	pos_t        e_hp;
	logic [15:0] e_len;
	logic [31:0] e_crc_end;
	logic [31:0] e_crc_cont;

	logic        need_pad;
	logic        at_boundary;
	logic        is_end;
	logic        do_hdr;
	logic        hdr_last;
	logic [31:0] hdr_crc;
	logic [7:0]  frag_type;
	logic [7:0]  hdr_byte;

	pos_t        nxt_wp;
	pos_t        nxt_hp;
	logic [15:0] nxt_len;
	logic        nxt_open;
	logic        nxt_first;
	logic [31:0] nxt_crc_end;
	logic [31:0] nxt_crc_cont;
	hdr_byte_t   nxt_hdr_idx;

	always_comb begin
		need_pad = !open_q && (wp_q[BLOCK_BITS-1:0] > PAD_LIMIT);

		// With no fragment open, the view is of one freshly opened at the write position.
		if (open_q) begin
			e_wp       = wp_q;
			e_hp       = hp_q;
			e_len      = len_q;
			e_crc_end  = crc_end_q;
			e_crc_cont = crc_cont_q;
		end else begin
			e_wp       = wp_q + pos_t'(HEADER_LEN);
			e_hp       = wp_q;
			e_len      = 16'h0000;
			e_crc_end  = first_q ? CRC_INIT_FULL : CRC_INIT_LAST;
			e_crc_cont = first_q ? CRC_INIT_FIRST : CRC_INIT_MIDDLE;
		end

		at_boundary = (e_wp[BLOCK_BITS-1:0] == '0);
		is_end      = (item_s1.func == FUNC_END);
		do_hdr      = is_end || at_boundary;
		hdr_last    = (hdr_idx_q == HB_TYPE);
		hdr_crc     = crc_mask(is_end ? e_crc_end : e_crc_cont);

		if (is_end) begin
			frag_type = first_q ? FRAG_FULL : FRAG_LAST;
		end else begin
			frag_type = first_q ? FRAG_FIRST : FRAG_MIDDLE;
		end

		unique case (hdr_idx_q)
			HB_CRC0:   hdr_byte = hdr_crc[7:0];
			HB_CRC1:   hdr_byte = hdr_crc[15:8];
			HB_CRC2:   hdr_byte = hdr_crc[23:16];
			HB_CRC3:   hdr_byte = hdr_crc[31:24];
			HB_LEN_LO: hdr_byte = e_len[7:0];
			HB_LEN_HI: hdr_byte = e_len[15:8];
			HB_TYPE:   hdr_byte = frag_type;
			default:   hdr_byte = 8'h00;
		endcase

		nxt_wp       = wp_q;
		nxt_hp       = hp_q;
		nxt_len      = len_q;
		nxt_open     = open_q;
		nxt_first    = first_q;
		nxt_crc_end  = crc_end_q;
		nxt_crc_cont = crc_cont_q;
		nxt_hdr_idx  = hdr_idx_q;

		if (need_pad) begin
			res.log_byte    = 8'h00;
			res.log_offset  = FIELD_W'(wp_q);
			res.kind        = KIND_PAD;
			res.last_result = 1'b0;
			nxt_wp          = wp_q + pos_t'(1);
		end else if (do_hdr) begin
			res.log_byte    = hdr_byte;
			res.log_offset  = FIELD_W'(e_hp + pos_t'(hdr_idx_q));
			res.kind        = KIND_HDR;
			res.last_result = is_end && hdr_last;
			nxt_wp          = e_wp;
			nxt_hp          = e_hp;
			nxt_len         = e_len;
			nxt_open        = 1'b1;
			nxt_crc_end     = e_crc_end;
			nxt_crc_cont    = e_crc_cont;
			if (!hdr_last) begin
				nxt_hdr_idx = hdr_byte_t'(hdr_idx_q + 3'd1);
			end else begin
				nxt_hdr_idx = HB_CRC0;
				nxt_len     = 16'h0000;
				if (is_end) begin
					nxt_open  = 1'b0;
					nxt_first = 1'b1;
				end else begin
					// The block is full: the next fragment opens at its start.
					nxt_first    = 1'b0;
					nxt_hp       = e_wp;
					nxt_wp       = e_wp + pos_t'(HEADER_LEN);
					nxt_crc_end  = CRC_INIT_LAST;
					nxt_crc_cont = CRC_INIT_MIDDLE;
				end
			end
		end else begin
			res.log_byte    = item_s1.data;
			res.log_offset  = FIELD_W'(e_wp);
			res.kind        = KIND_PAY;
			res.last_result = 1'b1;
			nxt_wp          = e_wp + pos_t'(1);
			nxt_hp          = e_hp;
			nxt_len         = e_len + 16'd1;
			nxt_open        = 1'b1;
			nxt_crc_end     = crc32c_byte(e_crc_end, item_s1.data);
			nxt_crc_cont    = crc32c_byte(e_crc_cont, item_s1.data);
		end

		res_push  = item_valid_s1 && res_ready;
		item_done = res_push && res.last_result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			len_q     <= 16'h0000;
			open_q    <= 1'b0;
			first_q   <= 1'b1;
			hdr_idx_q <= HB_CRC0;
		end else if (start_offset_we) begin
			wp_q      <= pos_t'(start_offset);
			len_q     <= 16'h0000;
			open_q    <= 1'b0;
			first_q   <= 1'b1;
			hdr_idx_q <= HB_CRC0;
		end else if (res_push) begin
			wp_q      <= nxt_wp;
			len_q     <= nxt_len;
			open_q    <= nxt_open;
			first_q   <= nxt_first;
			hdr_idx_q <= nxt_hdr_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			hp_q       <= nxt_hp;
			crc_end_q  <= nxt_crc_end;
			crc_cont_q <= nxt_crc_cont;
		end
	end

endmodule

@@ hw/rtl/lrbf_out_reg.sv @@
// Output register: holds one result word towards the log sink.
`timescale 1ns / 1ps
module lrbf_out_reg import lrbf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_push,
	input  result_t res,
	output logic    res_ready,
	output logic    log_valid,
	input  logic    log_stall,
	output result_t res_q
);

	assign res_ready = !log_valid || !log_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_valid <= 1'b0;
		end else if (res_push) begin
			log_valid <= 1'b1;
		end else if (!log_stall) begin
			log_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

endmodule

@@ hw/rtl/log_record_block_framer_unit.sv @@
// Top level of the log record block framer.
`timescale 1ns / 1ps
// Frames a stream of record bytes into a block-structured log with masked CRC32C
// fragment headers. Each input word (a payload byte or an end-of-record mark) gives
// one to thirteen log bytes, each with its file offset and kind; the framer makes
// one log byte per clock cycle while log_stall is low: a payload byte inside an
// open fragment gives one log byte, an end mark seven (plus up to six bytes of
// block padding), and a payload byte that meets a block boundary eight.
// The single output register sets the pace: one byte a cycle unless log_stall is high.
// The first log byte of a word passes the input register, then the output register.
// Headers appear after the payload of their fragment, at the offset reserved for them.
// Write start_offset only while idle; it also abandons any open fragment.
module log_record_block_framer_unit import lrbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_offset_we,
	input  logic [47:0] start_offset,
	input  logic        rec_valid,
	output logic        rec_stall,
	input  logic        func,
	input  logic [7:0]  payload_byte,
	output logic        log_valid,
	input  logic        log_stall,
	output logic [7:0]  log_byte,
	output logic [47:0] log_offset,
	output logic [1:0]  byte_kind,
	output logic        last_result
);

	item_t   item_in;
	item_t   item_s1;
	logic    item_valid_s1;
	logic    item_done;
	logic    res_push;
	logic    res_ready;
	result_t res;
	result_t res_q;

	assign item_in = '{func: func_t'(func), data: payload_byte};

	lrbf_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (rec_valid),
		.rec_stall     (rec_stall),
		.item_in       (item_in),
		.item_done     (item_done),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	lrbf_framer u_framer (
		.clk             (clk),
		.arst_n          (arst_n),
		.start_offset_we (start_offset_we),
		.start_offset    (field48_t'(start_offset)),
		.item_valid_s1   (item_valid_s1),
		.item_s1         (item_s1),
		.res_ready       (res_ready),
		.res_push        (res_push),
		.res             (res),
		.item_done       (item_done)
	);

	lrbf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res       (res),
		.res_ready (res_ready),
		.log_valid (log_valid),
		.log_stall (log_stall),
		.res_q     (res_q)
	);

	assign log_byte    = res_q.log_byte;
	assign log_offset  = 48'(res_q.log_offset);
	assign byte_kind   = 2'(res_q.kind);
	assign last_result = res_q.last_result;

endmodule

@@ hw/rtl/lrbf_checker.sv @@
// Port checker for the log record block framer, bound to its top level.
`timescale 1ns / 1ps
`include "log_record_block_framer_unit_assert.svh"
module lrbf_checker import lrbf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        log_valid,
	input logic        log_stall,
	input logic [7:0]  log_byte,
	input logic [47:0] log_offset,
	input logic [1:0]  byte_kind,
	input logic        last_result
);

	// A stalled word must stay put.
	`LRBF_ASSERT_NEXT(a_out_hold, clk, arst_n, log_valid && log_stall, log_valid && $stable(log_byte) && $stable(log_offset) && $stable(byte_kind) && $stable(last_result), "log word changed while stalled")

	// Only padding, header and payload kinds exist.
	`LRBF_ASSERT_SAME(a_kind_legal, clk, arst_n, log_valid, byte_kind == KIND_PAD || byte_kind == KIND_HDR || byte_kind == KIND_PAY, "illegal byte kind")

	// Padding always precedes a header, so it never closes a word.
	`LRBF_ASSERT_SAME(a_pad_not_last, clk, arst_n, log_valid && byte_kind == KIND_PAD, !last_result && log_byte == 8'h00, "padding byte marked last or non-zero")

	// A payload byte is always the final result of its input word.
	`LRBF_ASSERT_SAME(a_pay_last, clk, arst_n, log_valid && byte_kind == KIND_PAY, last_result, "payload byte not marked last")

endmodule

bind log_record_block_framer_unit lrbf_checker u_lrbf_checker (.*);

@@ tb/sv/log_record_block_framer_unit_tb.sv @@
// Testbench of the log record block framer: directed table, random records and a framing predictor.
`timescale 1ns / 1ps
module log_record_block_framer_unit_tb import lrbf_pkg::*;;

	localparam int RAND_WORDS   = 120;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 500000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start_offset_we;
	logic [47:0] start_offset;
	logic        rec_valid;
	logic        rec_stall;
	logic        func;
	logic [7:0]  payload_byte;
	logic        log_valid;
	logic        log_stall;
	logic [7:0]  log_byte;
	logic [47:0] log_offset;
	logic [1:0]  byte_kind;
	logic        last_result;

	log_record_block_framer_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start_offset_we (start_offset_we),
		.start_offset    (start_offset),
		.rec_valid       (rec_valid),
		.rec_stall       (rec_stall),
		.func            (func),
		.payload_byte    (payload_byte),
		.log_valid       (log_valid),
		.log_stall       (log_stall),
		.log_byte        (log_byte),
		.log_offset      (log_offset),
		.byte_kind       (byte_kind),
		.last_result     (last_result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Framer state as the predictor sees it.
	pos_t        wr_pos;
	pos_t        hdr_pos;
	logic [15:0] frag_len;
	bit          frag_open;
	bit          first_frag;
	logic [31:0] crc_end;
	logic [31:0] crc_cont;

	result_t expected_log_q[$];

	bit tx_idle;
	bit rx_idle;
	int errors = 0;
	int words_sent;
	int loads_done;
	int cycle_count = 0;
	int kind_seen[3] = '{0, 0, 0};

	typedef struct {
		bit         load;
		pos_t       value;
		func_t      f;
		logic [7:0] b;
		bit         typed;
		pos_t       t_off;
	} stim_row_t;

	stim_row_t stim_rows[$];

	function automatic logic [31:0] crc_step(logic [31:0] r, logic [7:0] b);
		logic [31:0] s;
		s = r;
		for (int k = 0; k < 8; k++) begin
			s = (s >> 1) ^ ((s[0] ^ b[k]) ? CRC_POLY : 32'h0);
		end
		return s;
	endfunction

	function automatic void note_byte(logic [7:0] b, pos_t pos, kind_t kind);
		result_t r;
		r.log_byte = b;
		r.log_offset = pos;
		r.kind = kind;
		r.last_result = 1'b0;
		expected_log_q.push_back(r);
	endfunction

	function automatic void frag_begin();
		blk_off_t used;
		int room;
		used = wr_pos[BLOCK_BITS-1:0];
		room = BLOCK_SIZE - int'(used);
		if (room < HEADER_LEN) begin
			repeat (room) begin
				note_byte(8'h00, wr_pos, KIND_PAD);
				wr_pos = wr_pos + pos_t'(1);
			end
		end
		hdr_pos = wr_pos;
		wr_pos = wr_pos + pos_t'(HEADER_LEN);
		frag_len = '0;
		frag_open = 1'b1;
		crc_end = crc_step(32'hFFFF_FFFF, first_frag ? FRAG_FULL : FRAG_LAST);
		crc_cont = crc_step(32'hFFFF_FFFF, first_frag ? FRAG_FIRST : FRAG_MIDDLE);
	endfunction

	function automatic void frag_close(bit ending);
		logic [7:0]  ftype;
		logic [31:0] c;
		logic [55:0] hdr;
		if (ending)
			ftype = first_frag ? FRAG_FULL : FRAG_LAST;
		else
			ftype = first_frag ? FRAG_FIRST : FRAG_MIDDLE;
		c = ~(ending ? crc_end : crc_cont);
		c = ((c >> 15) | (c << 17)) + CRC_MASK_DELTA;
		// Little-endian CRC, then length, then type.
		hdr = {ftype, frag_len, c};
		for (int i = 0; i < HEADER_LEN; i++) begin
			note_byte(hdr[8*i +: 8], hdr_pos + pos_t'(i), KIND_HDR);
		end
		frag_open = 1'b0;
	endfunction

	function automatic void predict_word(func_t f, logic [7:0] b);
		result_t tail;
		if (!frag_open)
			frag_begin();
		if (f == FUNC_DATA) begin
			// A full block closes the fragment and carries the record on in the next one.
			if (wr_pos[BLOCK_BITS-1:0] == '0) begin
				frag_close(1'b0);
				first_frag = 1'b0;
				frag_begin();
			end
			note_byte(b, wr_pos, KIND_PAY);
			crc_end = crc_step(crc_end, b);
			crc_cont = crc_step(crc_cont, b);
			frag_len = frag_len + 16'd1;
			wr_pos = wr_pos + pos_t'(1);
		end else begin
			frag_close(1'b1);
			first_frag = 1'b1;
			frag_len = '0;
		end
		tail = expected_log_q.pop_back();
		tail.last_result = 1'b1;
		expected_log_q.push_back(tail);
	endfunction

	function automatic void row_load(pos_t v);
		stim_row_t r;
		r = '{f: FUNC_DATA, default: '0};
		r.load = 1'b1;
		r.value = v;
		stim_rows.push_back(r);
	endfunction

	function automatic void row_word(func_t f, logic [7:0] b);
		stim_row_t r;
		r = '{f: FUNC_DATA, default: '0};
		r.f = f;
		r.b = b;
		stim_rows.push_back(r);
	endfunction

	// A payload byte inside an open fragment: one word out, at a known offset.
	function automatic void row_typed(logic [7:0] b, pos_t off);
		stim_row_t r;
		r = '{f: FUNC_DATA, default: '0};
		r.f = FUNC_DATA;
		r.b = b;
		r.typed = 1'b1;
		r.t_off = off;
		stim_rows.push_back(r);
	endfunction

	task automatic wait_drained();
		while (expected_log_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_start(pos_t v);
		rec_valid <= 1'b0;
		wait_drained();
		start_offset_we <= 1'b1;
		start_offset <= v;
		@(posedge clk);
		start_offset_we <= 1'b0;
		wr_pos = v;
		frag_open = 1'b0;
		first_frag = 1'b1;
		frag_len = '0;
		loads_done++;
	endtask

	task automatic send_word(func_t f, logic [7:0] b, bit typed, pos_t t_off);
		int gap;
		int mark;
		result_t r;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_valid <= 1'b1;
		func <= f;
		payload_byte <= b;
		do @(posedge clk); while (rec_stall);
		mark = expected_log_q.size();
		predict_word(f, b);
		if (typed) begin
			while (expected_log_q.size() > mark)
				void'(expected_log_q.pop_back());
			r.log_byte = b;
			r.log_offset = t_off;
			r.kind = KIND_PAY;
			r.last_result = 1'b1;
			expected_log_q.push_back(r);
		end
		words_sent++;
	endtask

	task automatic check_log_word();
		result_t want;
		if (expected_log_q.size() == 0) begin
			$display("%0t: log word expected none, actual byte %02h offset %012h kind %0d last %0b",
				$time, log_byte, log_offset, byte_kind, last_result);
			errors++;
			return;
		end
		want = expected_log_q.pop_front();
		if (log_byte !== want.log_byte) begin
			$display("%0t: log_byte expected %02h actual %02h", $time, want.log_byte, log_byte);
			errors++;
		end
		if (log_offset !== want.log_offset) begin
			$display("%0t: log_offset expected %012h actual %012h", $time, want.log_offset,
				log_offset);
			errors++;
		end
		if (byte_kind !== want.kind) begin
			$display("%0t: byte_kind expected %0d actual %0d", $time, want.kind, byte_kind);
			errors++;
		end
		if (last_result !== want.last_result) begin
			$display("%0t: last_result expected %0b actual %0b", $time, want.last_result,
				last_result);
			errors++;
		end
		if (want.kind <= KIND_PAY)
			kind_seen[want.kind]++;
	endtask

	// Log side: check every accepted word, then stall for a random number of cycles.
	initial begin
		int hold;
		hold = 0;
		log_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && log_valid && !log_stall) begin
				check_log_word();
				hold = rx_idle ? $urandom_range(0, 12) : 0;
			end else if (hold > 0) begin
				hold--;
			end
			log_stall <= (hold > 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int dir_words;
		int budget;
		int len;
		pos_t v;
		logic [63:0] r64;

		arst_n = 1'b0;
		start_offset_we = 1'b0;
		start_offset = '0;
		rec_valid = 1'b0;
		func = 1'b0;
		payload_byte = '0;
		words_sent = 0;
		loads_done = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;

		wr_pos = '0;
		hdr_pos = '0;
		frag_len = '0;
		frag_open = 1'b0;
		first_frag = 1'b1;
		crc_end = '0;
		crc_cont = '0;

		// After reset the log is empty, so the first header takes offsets 0 to 6.
		row_typed(8'h00, 48'd7);
		row_typed(8'hFF, 48'd8);
		row_word(FUNC_DATA, 8'h5A);
		row_word(FUNC_END, 8'h00);
		row_word(FUNC_END, 8'hFF);
		// Too little room for a header: the block tail is padded first.
		row_load(pos_t'(BLOCK_SIZE - 3));
		row_word(FUNC_DATA, 8'h11);
		row_word(FUNC_END, 8'h00);
		// A record that runs over into the next block.
		row_load(pos_t'(BLOCK_SIZE - 9));
		row_word(FUNC_DATA, 8'h01);
		row_word(FUNC_DATA, 8'h02);
		row_word(FUNC_DATA, 8'h03);
		row_word(FUNC_END, 8'h00);
		// The header fills the block exactly, which leaves an empty first fragment.
		row_load(pos_t'(BLOCK_SIZE - 7));
		row_word(FUNC_DATA, 8'h80);
		row_word(FUNC_DATA, 8'h7F);
		row_word(FUNC_END, 8'h00);
		// The record ends on the block boundary; the empty record after it opens the next block.
		row_load(pos_t'(BLOCK_SIZE - 8));
		row_typed(8'hC3, pos_t'(BLOCK_SIZE - 1));
		row_word(FUNC_END, 8'h00);
		row_word(FUNC_END, 8'h00);
		// Positions wrap at the top of the offset range.
		row_load(48'hFFFF_FFFF_FFF6);
		row_word(FUNC_DATA, 8'h3C);
		row_word(FUNC_DATA, 8'h0F);
		row_word(FUNC_DATA, 8'hF0);
		row_word(FUNC_DATA, 8'hAA);
		row_word(FUNC_END, 8'h00);
		// The largest offset; this fragment is left open and dropped by the next load.
		row_load(48'hFFFF_FFFF_FFFF);
		row_word(FUNC_DATA, 8'h55);
		row_word(FUNC_DATA, 8'h00);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].load)
				load_start(stim_rows[i].value);
			else
				send_word(stim_rows[i].f, stim_rows[i].b, stim_rows[i].typed, stim_rows[i].t_off);
		end
		dir_words = words_sent;

		// Random phases: a fresh start offset, mostly whole records and a little noise.
		while (words_sent - dir_words < RAND_WORDS) begin
			r64 = {$urandom(), $urandom()};
			case ($urandom_range(0, 4))
				0: v = '0;
				1: v = pos_t'(BLOCK_SIZE - $urandom_range(1, 40));
				2: v = 48'hFFFF_FFFF_FFFF - pos_t'($urandom_range(0, 60));
				3: v = r64[47:0];
				default: v = (r64[47:0] | pos_t'(BLOCK_SIZE - 1)) - pos_t'($urandom_range(0, 30));
			endcase
			load_start(v);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			budget = words_sent + $urandom_range(12, 32);
			while (words_sent < budget) begin
				if ($urandom_range(0, 5) == 0) begin
					send_word(func_t'($urandom_range(0, 1)), 8'($urandom()), 1'b0, '0);
				end else begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
					repeat (len) send_word(FUNC_DATA, 8'($urandom()), 1'b0, '0);
					send_word(FUNC_END, 8'($urandom()), 1'b0, '0);
				end
			end
		end

		rec_valid <= 1'b0;
		wait_drained();

		$display("summary: %0d words sent (%0d from the directed table), %0d offset loads",
			words_sent, dir_words, loads_done);
		$display("summary: log bytes checked: %0d padding, %0d header, %0d payload; %0d mismatches",
			kind_seen[0], kind_seen[1], kind_seen[2], errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
